// File: sv/ray_sphere_closest_hit_4d_defines.svh
// ---------------------------------------------------------------------------
// Ray/sphere closest hit: assertion macros
// Shared concurrent assertion helpers.
// ---------------------------------------------------------------------------
`ifndef RAY_SPHERE_CLOSEST_HIT_4D_DEFINES_SVH
`define RAY_SPHERE_CLOSEST_HIT_4D_DEFINES_SVH

// same-cycle implication
`define RSCH_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsch: same-cycle check failed");

// next-cycle implication
`define RSCH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsch: next-cycle check failed");

`endif

// File: sv/rsch_pkg.sv
// ---------------------------------------------------------------------------
// rsch_pkg
// Types and fixed constants of the ray/sphere closest-hit block.
// ---------------------------------------------------------------------------
package rsch_pkg;

   localparam int SLOT_W     = 10;
   localparam int CNT_W      = 11;
   localparam int MIND_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int MUL_SPLIT  = 24;

   localparam logic [MIND_W-1:0] MIN_DIST_RESET = 16'd7;   // ~1e-4 in Q.16

   localparam logic [CSR_IDX_W-1:0] CSR_SPHERE_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST     = 1'b1;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_TRACE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SWEEP = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

endpackage

// File: sv/ray_sphere_closest_hit_4d.sv
// ---------------------------------------------------------------------------
// ray_sphere_closest_hit_4d
// Closest-hit search of a ray against a table of 4D spheres, fixed point.
// ---------------------------------------------------------------------------
//  channel  | ports                 | transfer moves
//  ---------+-----------------------+-------------------------------------
//  req      | req_valid / req_ready | load (sphere into slot) or trace ray
//  rsp      | rsp_valid / rsp_ready | hit flag, slot, distance per trace
//  csr      | csr_we                | sphere_count, min_distance
//
//  Load: writes the sphere memory, no response.
//  Trace: with n = min(sphere_count, MAX_SPHERES), rsp_valid rises once the
//    n candidates have left the pipeline and the output register is free;
//    req_ready returns with it, so the next trace waits for that. The sphere
//    memory gives one entry per cycle to the intersection pipeline (POS_BITS
//    + 14 deep), whose depth is set mostly by the bit-per-stage square root.
//  Reset clears control and sphere_count, presets min_distance; memory is kept.
//  req stays low during a trace; a response waiting on rsp_ready holds only
//    the end of the next trace, loads keep flowing.
// ---------------------------------------------------------------------------
`include "ray_sphere_closest_hit_4d_defines.svh"

module ray_sphere_closest_hit_4d #(
   parameter int MAX_SPHERES = 1024,
   parameter int POS_BITS    = 40,
   parameter int DIR_BITS    = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [rsch_pkg::SLOT_W-1:0]   req_slot,
   input  logic signed [POS_BITS-1:0]    req_pos_x,
   input  logic signed [POS_BITS-1:0]    req_pos_y,
   input  logic signed [POS_BITS-1:0]    req_pos_z,
   input  logic signed [POS_BITS-1:0]    req_pos_w,
   input  logic [POS_BITS-2:0]           req_sphere_radius,
   input  logic signed [DIR_BITS-1:0]    req_dir_x,
   input  logic signed [DIR_BITS-1:0]    req_dir_y,
   input  logic signed [DIR_BITS-1:0]    req_dir_z,
   input  logic signed [DIR_BITS-1:0]    req_dir_w,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit_flag,
   output logic [rsch_pkg::SLOT_W-1:0]   rsp_hit_slot,
   output logic [POS_BITS-2:0]           rsp_hit_distance,
   // config write port
   input  logic                          csr_we,
   input  logic [rsch_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rsch_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rsch_pkg::*;

   localparam int AW  = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
   localparam int CW  = AW + 1;                       // holds MAX_SPHERES
   localparam int NW  = (CNT_W > CW) ? CNT_W : CW;
   localparam int XW  = AW + SLOT_W + 1;
   localparam int P   = POS_BITS;
   localparam int EW  = 5 * P - 1;
   localparam int T_W = P + 7;
   localparam int DW  = P - 1;

   // ---------------- config registers ----------------
   logic [CNT_W-1:0]  count_ff;
   logic [MIND_W-1:0] min_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         min_dist_ff <= MIN_DIST_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPHERE_COUNT: count_ff    <= csr_wdata[CNT_W-1:0];
            CSR_MIN_DIST:     min_dist_ff <= csr_wdata[MIND_W-1:0];
            default: ;
         endcase
      end
   end

   // effective sweep length, clamped to the table depth
   logic [NW-1:0] cnt_x;
   logic [CW-1:0] n_eff;
   assign cnt_x = NW'(count_ff);
   assign n_eff = (cnt_x > NW'(MAX_SPHERES)) ? CW'(MAX_SPHERES) : CW'(cnt_x);

   // ---------------- control ----------------
   state_type     state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] inflight_ff, inflight_in;
   logic          req_xfer, trace_go, load_we, issue, rsp_load;
   logic [XW-1:0] slot_x;
   logic          slot_ok;
   logic          rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign slot_x    = XW'(req_slot);
   assign slot_ok   = (slot_x < XW'(MAX_SPHERES));
   assign load_we   = req_xfer && (req_cmd == CMD_LOAD) && slot_ok;
   assign trace_go  = req_xfer && (req_cmd == CMD_TRACE);
   assign issue     = (state_ff == ST_SWEEP) && (idx_ff < n_eff);

   // candidates drain out of the pipe; response waits for a free output reg
   logic cand_valid;
   assign rsp_load = (state_ff == ST_DRAIN) && (inflight_ff == '0)
                   && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (trace_go) begin
               state_in = ST_SWEEP;
               idx_in   = '0;
            end
         end
         ST_SWEEP: begin
            if (issue) idx_in = idx_ff + 1'b1;
            else       state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      inflight_in = inflight_ff;
      if (issue && !cand_valid)      inflight_in = inflight_ff + 1'b1;
      else if (!issue && cand_valid) inflight_in = inflight_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         idx_ff      <= '0;
         inflight_ff <= '0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         inflight_ff <= inflight_in;
      end
   end

   // ---------------- ray registers ----------------
   logic signed [P-1:0]        origin_ff [4];
   logic signed [DIR_BITS-1:0] dir_ff    [4];

   always_ff @(posedge clock) begin
      if (trace_go) begin
         origin_ff[0] <= req_pos_x;
         origin_ff[1] <= req_pos_y;
         origin_ff[2] <= req_pos_z;
         origin_ff[3] <= req_pos_w;
         dir_ff[0]    <= req_dir_x;
         dir_ff[1]    <= req_dir_y;
         dir_ff[2]    <= req_dir_z;
         dir_ff[3]    <= req_dir_w;
      end
   end

   // ---------------- sphere memory ----------------
   // entry = {radius, w, z, y, x}; writes only in idle, reads only in sweep,
   // so the two never touch the same cycle.
   logic [EW-1:0] mem [MAX_SPHERES];
   logic [EW-1:0] rd_data_ff;
   logic          rd_v_ff;
   logic [AW-1:0] rd_slot_ff;

   always_ff @(posedge clock) begin
      if (load_we) begin
         mem[slot_x[AW-1:0]] <= {req_sphere_radius, req_pos_w, req_pos_z,
                                 req_pos_y, req_pos_x};
      end
      if (issue) begin
         rd_data_ff <= mem[idx_ff[AW-1:0]];
      end
      rd_slot_ff <= idx_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) rd_v_ff <= 1'b0;
      else       rd_v_ff <= issue;
   end

   logic signed [P-1:0] centre [4];
   logic [P-2:0]        radius;

   assign centre[0] = $signed(rd_data_ff[P-1:0]);
   assign centre[1] = $signed(rd_data_ff[2*P-1:P]);
   assign centre[2] = $signed(rd_data_ff[3*P-1:2*P]);
   assign centre[3] = $signed(rd_data_ff[4*P-1:3*P]);
   assign radius    = rd_data_ff[EW-1:4*P];

   // ---------------- intersection pipeline ----------------
   logic [AW-1:0]         cand_slot;
   logic                  cand_hit;
   logic signed [T_W-1:0] cand_t;

   rsch_isect #(.P(P), .D(DIR_BITS), .AW(AW)) u_isect (
      .clock(clock), .reset(reset),
      .in_valid(rd_v_ff), .in_slot(rd_slot_ff),
      .in_centre(centre), .in_radius(radius),
      .in_origin(origin_ff), .in_dir(dir_ff), .in_min_dist(min_dist_ff),
      .out_valid(cand_valid), .out_slot(cand_slot),
      .out_hit(cand_hit), .out_t(cand_t));

   // ---------------- closest-hit tracking ----------------
   // slots come out in ascending order, so strict less-than keeps the
   // lower slot on a tie
   logic                  found_ff;
   logic [AW-1:0]         best_slot_ff;
   logic signed [T_W-1:0] best_t_ff;
   logic                  take;

   assign take = cand_valid && cand_hit && (!found_ff || (cand_t < best_t_ff));

   always_ff @(posedge clock) begin
      if (reset || trace_go) found_ff <= 1'b0;
      else if (take)         found_ff <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_slot_ff <= cand_slot;
         best_t_ff    <= cand_t;
      end
   end

   // ---------------- response register ----------------
   logic          flag_ff;
   logic [SLOT_W-1:0] hslot_ff;
   logic [DW-1:0] dist_ff;
   logic          sat;

   assign sat = |best_t_ff[T_W-1:DW];   // best_t is always positive

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         flag_ff  <= found_ff;
         hslot_ff <= found_ff ? SLOT_W'(best_slot_ff) : '0;
         dist_ff  <= (!found_ff || sat) ? '1 : best_t_ff[DW-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit_flag     = flag_ff;
   assign rsp_hit_slot     = hslot_ff;
   assign rsp_hit_distance = dist_ff;

   // ---------------- checks ----------------
   `RSCH_ASSERT_NOW(a_cand_tracked, clock, reset, cand_valid, inflight_ff != '0)
   `RSCH_ASSERT_NOW(a_idle_empty, clock, reset, state_ff == ST_IDLE, inflight_ff == '0 && !rd_v_ff)
   `RSCH_ASSERT_NEXT(a_first_hit, clock, reset, cand_valid && cand_hit && !found_ff, found_ff && best_slot_ff == $past(cand_slot))
   `RSCH_ASSERT_NOW(a_rsp_after_drain, clock, reset, rsp_load, !issue && !rd_v_ff && !cand_valid)

endmodule

// File: sv/rsch_smul.sv
// ---------------------------------------------------------------------------
// rsch_smul
// Signed multiplier: four registered partial products, summed into an output register.
// ---------------------------------------------------------------------------
module rsch_smul #(
   parameter int A_W = 41,
   parameter int B_W = 32
) (
   input  logic                       clock,
   input  logic signed [A_W-1:0]      in_a,
   input  logic signed [B_W-1:0]      in_b,
   output logic signed [A_W+B_W-1:0]  out_p
);
   import rsch_pkg::*;

   localparam int S  = MUL_SPLIT;
   localparam int AX = (A_W > S) ? A_W : S + 1;
   localparam int BX = (B_W > S) ? B_W : S + 1;
   localparam int HA = AX - S;
   localparam int HB = BX - S;
   localparam int SW = AX + BX;

   logic signed [AX-1:0] ax;
   logic signed [BX-1:0] bx;
   logic signed [S:0]    al, bl;
   logic signed [HA-1:0] ah;
   logic signed [HB-1:0] bh;

   logic signed [2*S+1:0]   pll_ff;
   logic signed [S+HB:0]    plh_ff;
   logic signed [HA+S:0]    phl_ff;
   logic signed [HA+HB-1:0] phh_ff;
   logic signed [SW-1:0]    sum;
   logic signed [A_W+B_W-1:0] p_ff;

   assign ax = AX'(in_a);
   assign bx = BX'(in_b);
   assign al = $signed({1'b0, ax[S-1:0]});
   assign bl = $signed({1'b0, bx[S-1:0]});
   assign ah = $signed(ax[AX-1:S]);
   assign bh = $signed(bx[BX-1:S]);

   always_ff @(posedge clock) begin
      pll_ff <= al * bl;
      plh_ff <= al * bh;
      phl_ff <= ah * bl;
      phh_ff <= ah * bh;
   end

   assign sum = SW'(pll_ff) + (SW'(plh_ff) <<< S) + (SW'(phl_ff) <<< S)
              + (SW'(phh_ff) <<< (2 * S));

   always_ff @(posedge clock) begin
      p_ff <= sum[A_W+B_W-1:0];
   end

   assign out_p = p_ff;

endmodule

// File: sv/rsch_isqrt.sv
// ---------------------------------------------------------------------------
// rsch_isqrt
// Pipelined truncating integer square root, one root bit per stage,
// with a side tag carried alongside.
// ---------------------------------------------------------------------------
module rsch_isqrt #(
   parameter int N   = 45,
   parameter int TGW = 56
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [2*N-1:0]   in_rad,
   input  logic [TGW-1:0]   in_tag,
   output logic             out_valid,
   output logic [N-1:0]     out_root,
   output logic [TGW-1:0]   out_tag
);
   import rsch_pkg::*;

   logic [N:0]     rem_ff  [N];
   logic [N-1:0]   root_ff [N];
   logic [2*N-1:0] rest_ff [N];
   logic [TGW-1:0] tag_ff  [N];
   logic [N-1:0]   v_ff;

   logic [N:0]     src_rem  [N];
   logic [N-1:0]   src_root [N];
   logic [2*N-1:0] src_rest [N];
   logic [TGW-1:0] src_tag  [N];
   logic [N-1:0]   src_v;

   logic [N+2:0]   acc   [N];
   logic [N+2:0]   trial [N];
   logic [N+2:0]   diff  [N];
   logic [N-1:0]   ge;

   always_comb begin
      src_rem[0]  = '0;
      src_root[0] = '0;
      src_rest[0] = in_rad;
      src_tag[0]  = in_tag;
      src_v[0]    = in_valid;
      for (int k = 1; k < N; k++) begin
         src_rem[k]  = rem_ff[k-1];
         src_root[k] = root_ff[k-1];
         src_rest[k] = rest_ff[k-1];
         src_tag[k]  = tag_ff[k-1];
         src_v[k]    = v_ff[k-1];
      end
   end

   always_comb begin
      for (int k = 0; k < N; k++) begin
         acc[k]   = {src_rem[k], src_rest[k][2*N-1:2*N-2]};
         trial[k] = {1'b0, src_root[k], 2'b01};
         diff[k]  = acc[k] - trial[k];
         ge[k]    = (acc[k] >= trial[k]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         rem_ff[k]  <= ge[k] ? diff[k][N:0] : acc[k][N:0];
         root_ff[k] <= {src_root[k][N-2:0], ge[k]};
         rest_ff[k] <= {src_rest[k][2*N-3:0], 2'b00};
         tag_ff[k]  <= src_tag[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= src_v;
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_tag   = tag_ff[N-1];

endmodule

// File: sv/rsch_isect.sv
// ---------------------------------------------------------------------------
// rsch_isect
// Intersection pipeline: one sphere per cycle in, one candidate distance out.
// ---------------------------------------------------------------------------
module rsch_isect #(
   parameter int P  = 40,
   parameter int D  = 32,
   parameter int AW = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [AW-1:0]        in_slot,
   input  logic signed [P-1:0]  in_centre [4],
   input  logic [P-2:0]         in_radius,
   input  logic signed [P-1:0]  in_origin [4],
   input  logic signed [D-1:0]  in_dir [4],
   input  logic [rsch_pkg::MIND_W-1:0] in_min_dist,
   output logic                 out_valid,
   output logic [AW-1:0]        out_slot,
   output logic                 out_hit,
   output logic signed [P+6:0]  out_t
);
   import rsch_pkg::*;

   localparam int OCW   = P + 1;
   localparam int PW    = OCW + D;
   localparam int DOTW  = PW + 2;
   localparam int F     = D - 2;
   localparam int BW    = DOTW - F;
   localparam int DISCW = 2 * BW + 2;
   localparam int TW    = BW + 2;
   localparam int TGW   = AW + BW + 1;

   // stage A: oc = centre - origin
   logic signed [OCW-1:0] oc_ff [4];
   logic signed [P-1:0]   rad_ff;
   logic                  v_a_ff;
   logic [AW-1:0]         slot_a_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         oc_ff[k] <= OCW'(in_centre[k]) - OCW'(in_origin[k]);
      end
      rad_ff    <= $signed({1'b0, in_radius});
      slot_a_ff <= in_slot;
   end

   // products
   logic signed [PW-1:0]    dp   [4];
   logic signed [2*OCW-1:0] sq   [4];
   logic signed [2*P-1:0]   rr;

   for (genvar k = 0; k < 4; k++) begin : g_mul
      rsch_smul #(.A_W(OCW), .B_W(D)) u_dot (
         .clock(clock), .in_a(oc_ff[k]), .in_b(in_dir[k]), .out_p(dp[k]));
      rsch_smul #(.A_W(OCW), .B_W(OCW)) u_sq (
         .clock(clock), .in_a(oc_ff[k]), .in_b(oc_ff[k]), .out_p(sq[k]));
   end

   rsch_smul #(.A_W(P), .B_W(P)) u_rr (
      .clock(clock), .in_a(rad_ff), .in_b(rad_ff), .out_p(rr));

   logic          v_m_ff [2];
   logic [AW-1:0] slot_m_ff [2];

   always_ff @(posedge clock) begin
      slot_m_ff[0] <= slot_a_ff;
      slot_m_ff[1] <= slot_m_ff[0];
   end

   // stage B: dot sum and rr - |oc|^2
   logic signed [DOTW-1:0]  dot_ff;
   logic signed [DISCW-1:0] part_b_ff;
   logic                    v_b_ff;
   logic [AW-1:0]           slot_b_ff;

   always_ff @(posedge clock) begin
      dot_ff <= DOTW'(dp[0]) + DOTW'(dp[1]) + DOTW'(dp[2]) + DOTW'(dp[3]);
      part_b_ff <= DISCW'(rr) - DISCW'(sq[0]) - DISCW'(sq[1])
                 - DISCW'(sq[2]) - DISCW'(sq[3]);
      slot_b_ff <= slot_m_ff[1];
   end

   // stage C: b = floor(dot / 2^F)
   logic signed [BW-1:0]    b_ff;
   logic signed [DISCW-1:0] part_c_ff;
   logic                    v_c_ff;
   logic [AW-1:0]           slot_c_ff;

   always_ff @(posedge clock) begin
      b_ff      <= $signed(dot_ff[DOTW-1:F]);
      part_c_ff <= part_b_ff;
      slot_c_ff <= slot_b_ff;
   end

   logic signed [2*BW-1:0] bb;

   rsch_smul #(.A_W(BW), .B_W(BW)) u_bb (
      .clock(clock), .in_a(b_ff), .in_b(b_ff), .out_p(bb));

   logic signed [DISCW-1:0] part_q_ff [2];
   logic signed [BW-1:0]    b_q_ff    [2];
   logic                    v_q_ff    [2];
   logic [AW-1:0]           slot_q_ff [2];

   always_ff @(posedge clock) begin
      part_q_ff[0] <= part_c_ff;
      part_q_ff[1] <= part_q_ff[0];
      b_q_ff[0]    <= b_ff;
      b_q_ff[1]    <= b_q_ff[0];
      slot_q_ff[0] <= slot_c_ff;
      slot_q_ff[1] <= slot_q_ff[0];
   end

   // stage D: discriminant
   logic signed [DISCW-1:0] disc_ff;
   logic signed [BW-1:0]    b_d_ff;
   logic                    v_d_ff;
   logic [AW-1:0]           slot_d_ff;
   logic                    pos;

   always_ff @(posedge clock) begin
      disc_ff   <= DISCW'(bb) + part_q_ff[1];
      b_d_ff    <= b_q_ff[1];
      slot_d_ff <= slot_q_ff[1];
   end

   assign pos = (disc_ff > 0);

   // square root with {pos, slot, b} riding along
   logic [BW-1:0]  root;
   logic [TGW-1:0] tag_out;
   logic           v_s;
   logic [2*BW-1:0] rad_in;

   assign rad_in = pos ? disc_ff[2*BW-1:0] : '0;

   rsch_isqrt #(.N(BW), .TGW(TGW)) u_sqrt (
      .clock(clock), .reset(reset), .in_valid(v_d_ff), .in_rad(rad_in),
      .in_tag({pos, slot_d_ff, b_d_ff}),
      .out_valid(v_s), .out_root(root), .out_tag(tag_out));

   // stage E: pick root against min distance
   logic signed [TW-1:0] bt, st, t1, t2, md;
   logic                 s_pos;

   assign s_pos = tag_out[TGW-1];
   assign bt    = TW'($signed(tag_out[BW-1:0]));
   assign st    = $signed({2'b00, root});
   assign t1    = bt - st;
   assign t2    = bt + st;
   assign md    = $signed(TW'({1'b0, in_min_dist}));

   logic                 v_e_ff;
   logic                 hit_ff;
   logic [AW-1:0]        slot_e_ff;
   logic signed [TW-1:0] t_ff;

   always_ff @(posedge clock) begin
      hit_ff    <= s_pos && ((t1 > md) || (t2 > md));
      t_ff      <= (t1 > md) ? t1 : t2;
      slot_e_ff <= tag_out[TGW-2:BW];
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff    <= 1'b0;
         v_m_ff[0] <= 1'b0;
         v_m_ff[1] <= 1'b0;
         v_b_ff    <= 1'b0;
         v_c_ff    <= 1'b0;
         v_q_ff[0] <= 1'b0;
         v_q_ff[1] <= 1'b0;
         v_d_ff    <= 1'b0;
         v_e_ff    <= 1'b0;
      end else begin
         v_a_ff    <= in_valid;
         v_m_ff[0] <= v_a_ff;
         v_m_ff[1] <= v_m_ff[0];
         v_b_ff    <= v_m_ff[1];
         v_c_ff    <= v_b_ff;
         v_q_ff[0] <= v_c_ff;
         v_q_ff[1] <= v_q_ff[0];
         v_d_ff    <= v_q_ff[1];
         v_e_ff    <= v_s;
      end
   end

   assign out_valid = v_e_ff;
   assign out_slot  = slot_e_ff;
   assign out_hit   = hit_ff;
   assign out_t     = t_ff;

endmodule

// File: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: ray_sphere_closest_hit_4d testbench
// Loads spheres and traces rays through the req channel, predicts the closest
// hit of every trace in fixed point, and checks each rsp transfer in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import rsch_pkg::*;

   localparam int          NSLOT    = 1024;
   localparam longint      UNIT     = 64'sd65536;           // 1.0 in Q.16
   localparam longint      POS_MAX  = 64'sd549755813887;
   localparam longint      POS_MIN  = -64'sd549755813888;
   localparam longint      RAD_MAX  = 64'sd549755813887;
   localparam longint      DIST_MAX = 64'sd549755813887;
   localparam int          DIR_ONE  = 32'sh4000_0000;       // 1.0 in Q1.30
   localparam int          DIR_MIN  = 32'sh8000_0000;
   localparam int          DIR_MAX  = 32'sh7fff_ffff;
   localparam longint      LIMIT    = 64'd5000000;

   typedef struct {
      logic                cmd;
      logic [SLOT_W-1:0]   slot;
      logic signed [39:0]  pos[4];
      logic [38:0]         radius;
      logic signed [31:0]  dir[4];
   } sphere_req_type;

   typedef struct {
      logic                flag;
      logic [SLOT_W-1:0]   slot;
      logic [38:0]         hit_dist;
   } hit_type;

   // Sphere table mirror, config copy and queue of pending hits.
   class hit_scoreboard;
      longint signed   cen[NSLOT][4];
      longint unsigned rad[NSLOT];
      bit              loaded[NSLOT];
      int unsigned     sphere_count;
      longint signed   min_dist;
      hit_type         pending_hits[$];
      int              errors;

      function new();
         sphere_count = 0;
         min_dist     = MIN_DIST_RESET;
         errors       = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
         if (idx == CSR_SPHERE_COUNT) sphere_count = v[CNT_W-1:0];
         else if (idx == CSR_MIN_DIST) min_dist = v;
      endfunction

      function int loaded_prefix();
         int n;
         n = 0;
         while (n < NSLOT && loaded[n]) n++;
         return n;
      endfunction

      // truncating square root, bit per step
      function longint unsigned isqrt128(logic [127:0] v);
         longint unsigned res, cand;
         logic [127:0]    sq;
         res = 0;
         for (int bt = 63; bt >= 0; bt--) begin
            cand = res | (64'd1 << bt);
            sq   = {64'd0, cand} * {64'd0, cand};
            if (sq <= v) res = cand;
         end
         return res;
      endfunction

      function hit_type closest_hit(sphere_req_type it);
         longint signed      p[4], d[4], oc[4];
         longint signed      b, s, t, best_t;
         logic signed [127:0] dot, disc, w_oc, w_d, w_b, w_r, sh;
         int                 n, best;
         bit                 found;
         hit_type            h;
         for (int k = 0; k < 4; k++) begin
            p[k] = it.pos[k];
            d[k] = it.dir[k];
         end
         n      = (sphere_count > NSLOT) ? NSLOT : sphere_count;
         found  = 0;
         best   = 0;
         best_t = 0;
         for (int i = 0; i < n; i++) begin
            dot = 0;
            for (int k = 0; k < 4; k++) begin
               oc[k] = cen[i][k] - p[k];
               w_oc  = oc[k];
               w_d   = d[k];
               dot   = dot + w_oc * w_d;
            end
            sh   = dot >>> 30;                  // floor to Q.16
            b    = sh[63:0];
            w_b  = b;
            disc = w_b * w_b;
            for (int k = 0; k < 4; k++) begin
               w_oc = oc[k];
               disc = disc - w_oc * w_oc;
            end
            w_r  = {64'd0, rad[i]};
            disc = disc + w_r * w_r;
            if (disc <= 0) continue;
            s = isqrt128(disc);
            t = b - s;                          // near root first
            if (!(t > min_dist)) begin
               t = b + s;
               if (!(t > min_dist)) continue;
            end
            if (!found || t < best_t) begin     // strict: lower slot keeps a tie
               found  = 1;
               best_t = t;
               best   = i;
            end
         end
         h.flag     = found;
         h.slot     = found ? best[SLOT_W-1:0] : '0;
         h.hit_dist = (!found || best_t > DIST_MAX) ? DIST_MAX[38:0] : best_t[38:0];
         return h;
      endfunction

      function void note_request(sphere_req_type it);
         if (it.cmd == CMD_LOAD) begin
            for (int k = 0; k < 4; k++) cen[it.slot][k] = it.pos[k];
            rad[it.slot]    = it.radius;
            loaded[it.slot] = 1;
         end else begin
            pending_hits.insert(pending_hits.size(), closest_hit(it));
         end
      endfunction

      function void check_response(hit_type got);
         hit_type e;
         if (pending_hits.size() == 0) begin
            $error("rsp transfer with no trace outstanding");
            errors++;
            return;
         end
         e = pending_hits.pop_front();
         if (got.flag !== e.flag) begin
            $error("hit_flag expected %0d got %0d", e.flag, got.flag);
            errors++;
         end
         if (got.slot !== e.slot) begin
            $error("hit_slot expected %0d got %0d", e.slot, got.slot);
            errors++;
         end
         if (got.hit_dist !== e.hit_dist) begin
            $error("hit_distance expected %0h got %0h", e.hit_dist, got.hit_dist);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid, req_ready, req_cmd;
   logic [SLOT_W-1:0]      req_slot;
   logic signed [39:0]     req_pos_x, req_pos_y, req_pos_z, req_pos_w;
   logic [38:0]            req_sphere_radius;
   logic signed [31:0]     req_dir_x, req_dir_y, req_dir_z, req_dir_w;
   logic                   rsp_valid, rsp_ready, rsp_hit_flag;
   logic [SLOT_W-1:0]      rsp_hit_slot;
   logic [38:0]            rsp_hit_distance;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   ray_sphere_closest_hit_4d dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_slot(req_slot),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z), .req_pos_w(req_pos_w),
      .req_sphere_radius(req_sphere_radius),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y),
      .req_dir_z(req_dir_z), .req_dir_w(req_dir_w),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_hit_flag(rsp_hit_flag), .rsp_hit_slot(rsp_hit_slot),
      .rsp_hit_distance(rsp_hit_distance),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   hit_scoreboard sb = new();

   int     send_idle_pct = 0;   // chance the sender sits out a cycle
   int     recv_stall_pct = 0;  // chance the receiver drops rsp_ready
   bit     hold_req = 0;        // asks the receiver for one long hold-off
   longint cycles = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Watchdog: anything past the limit means the block hung.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver: values read right after the edge are the ones the edge sampled.
   initial begin : receiver
      int      hold_left;
      hit_type got;
      hold_left = 0;
      rsp_ready = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.flag     = rsp_hit_flag;
            got.slot     = rsp_hit_slot;
            got.hit_dist = rsp_hit_distance;
            sb.check_response(got);
         end
         if (hold_req) begin
            hold_req  = 0;
            hold_left = 4000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic sphere_req_type mk(logic cmd, int slot, longint x, longint y,
                                         longint z, longint w, longint r,
                                         int dx, int dy, int dz, int dw);
      sphere_req_type it;
      it.cmd    = cmd;
      it.slot   = slot;
      it.pos[0] = x;  it.pos[1] = y;  it.pos[2] = z;  it.pos[3] = w;
      it.radius = r;
      it.dir[0] = dx; it.dir[1] = dy; it.dir[2] = dz; it.dir[3] = dw;
      return it;
   endfunction

   function automatic longint rnd_box(int units);
      return longint'($urandom_range(2 * units * 65536)) - longint'(units) * UNIT;
   endfunction

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   // Mostly well-formed loads and traces near the origin; some full-range noise.
   function automatic sphere_req_type rnd_req(int load_cap);
      sphere_req_type it;
      int             pick, ax;
      logic [63:0]    v;
      pick = $urandom_range(99);
      if (pick < 10) begin
         it.cmd  = $urandom_range(1);
         it.slot = $urandom_range(NSLOT - 1);
         for (int k = 0; k < 4; k++) begin
            v = rnd64();  it.pos[k] = v[39:0];
            it.dir[k] = $urandom;
         end
         v = rnd64();
         it.radius = v[38:0];
         return it;
      end
      for (int k = 0; k < 4; k++) it.pos[k] = rnd_box(64);
      it.slot   = $urandom_range(load_cap);
      it.radius = $urandom_range(16 * 65536, 65536 / 4);
      if (pick < 40) begin
         it.cmd = CMD_LOAD;
         for (int k = 0; k < 4; k++) it.dir[k] = $urandom;
      end else begin
         it.cmd = CMD_TRACE;
         if ($urandom_range(1)) begin
            ax = $urandom_range(3);
            for (int k = 0; k < 4; k++)
               it.dir[k] = (k == ax) ? ($urandom_range(1) ? DIR_ONE : -DIR_ONE) : 0;
         end else begin
            for (int k = 0; k < 4; k++)
               it.dir[k] = int'($urandom_range(DIR_ONE)) - DIR_ONE / 2;
         end
      end
      return it;
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      sb.write_reg(idx, v);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // One transfer on req; valid stays up into the next item unless a gap falls.
   task automatic send_req(sphere_req_type it);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid         <= 1'b1;
      req_cmd           <= it.cmd;
      req_slot          <= it.slot;
      req_pos_x         <= it.pos[0];
      req_pos_y         <= it.pos[1];
      req_pos_z         <= it.pos[2];
      req_pos_w         <= it.pos[3];
      req_sphere_radius <= it.radius;
      req_dir_x         <= it.dir[0];
      req_dir_y         <= it.dir[1];
      req_dir_z         <= it.dir[2];
      req_dir_w         <= it.dir[3];
      do @(posedge clock); while (!req_ready);
      sb.note_request(it);
   endtask

   // Close a phase: drop valid, let every trace answer, then let loads settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_hits.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   initial begin : stimulus
      int cap, cnt;
      req_valid = 0;  req_cmd = 0;  req_slot = 0;
      req_pos_x = 0;  req_pos_y = 0;  req_pos_z = 0;  req_pos_w = 0;
      req_sphere_radius = 0;
      req_dir_x = 0;  req_dir_y = 0;  req_dir_z = 0;  req_dir_w = 0;
      csr_we = 0;  csr_index = 0;  csr_wdata = 0;
      reset = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, extreme fields, table setup.
      send_req(mk(CMD_TRACE, 0, POS_MAX, POS_MAX, POS_MIN, POS_MIN, 0,
                  DIR_MIN, DIR_MAX, DIR_MIN, DIR_MAX));
      send_req(mk(CMD_LOAD, 0, 10 * UNIT, 0, 0, 0, 2 * UNIT, 0, 0, 0, 0));
      send_req(mk(CMD_LOAD, 1, POS_MAX, 0, 0, 0, UNIT, 0, 0, 0, 0));
      send_req(mk(CMD_LOAD, 2, 0, 20 * UNIT, 0, 0, 3 * UNIT, 0, 0, 0, 0));
      send_req(mk(CMD_LOAD, 3, 0, 20 * UNIT, 0, 0, 3 * UNIT, 0, 0, 0, 0));
      send_req(mk(CMD_LOAD, NSLOT - 1, POS_MIN, POS_MIN, POS_MIN, POS_MIN, RAD_MAX,
                  DIR_MIN, DIR_MIN, DIR_MIN, DIR_MIN));
      drain();

      // Plain hit, saturated distance, origin inside (far root), tie on equal
      // spheres, non-unit direction, misses.
      write_csr(CSR_SPHERE_COUNT, 4);
      send_req(mk(CMD_TRACE, 0, 0, 0, 0, 0, 0, DIR_ONE, 0, 0, 0));
      send_req(mk(CMD_TRACE, 0, POS_MIN, 0, 0, 0, 0, DIR_ONE, 0, 0, 0));
      send_req(mk(CMD_TRACE, 0, 10 * UNIT, 0, 0, 0, 0, DIR_ONE, 0, 0, 0));
      send_req(mk(CMD_TRACE, 0, 0, 0, 0, 0, 0, 0, DIR_ONE, 0, 0));
      send_req(mk(CMD_TRACE, 0, 0, 0, 0, 0, 0, DIR_MIN, 0, 0, 0));
      send_req(mk(CMD_TRACE, 0, 20 * UNIT, 0, 0, 0, 0, DIR_MIN, 0, 0, 0));
      send_req(mk(CMD_TRACE, 0, 0, 0, 0, 0, 0, 0, -DIR_ONE, 0, 0));
      send_req(mk(CMD_TRACE, 0, 0, 0, 0, 0, 0, 0, 0, 0, DIR_ONE));
      drain();

      // Largest guard distance, then none at all: root of exactly zero rejected.
      write_csr(CSR_MIN_DIST, 16'hffff);
      send_req(mk(CMD_TRACE, 0, 7 * UNIT, 0, 0, 0, 0, DIR_ONE, 0, 0, 0));
      send_req(mk(CMD_TRACE, 0, 7 * UNIT + 1, 0, 0, 0, 0, DIR_ONE, 0, 0, 0));
      drain();
      write_csr(CSR_MIN_DIST, 0);
      send_req(mk(CMD_TRACE, 0, 8 * UNIT, 0, 0, 0, 0, DIR_ONE, 0, 0, 0));
      drain();

      // Random phases: idle pattern rotates, one phase with a long rsp hold-off.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         cap = sb.loaded_prefix();
         cnt = (cap > 24) ? 24 : cap;
         write_csr(CSR_SPHERE_COUNT, (ph == 5) ? cap : $urandom_range(cnt, 1));
         case ($urandom_range(3))
            0: write_csr(CSR_MIN_DIST, 0);
            1: write_csr(CSR_MIN_DIST, 16'hffff);
            2: write_csr(CSR_MIN_DIST, MIN_DIST_RESET);
            default: write_csr(CSR_MIN_DIST, $urandom_range(16'hffff));
         endcase
         if (ph == 4) hold_req = 1;   // receiver stops; block must back up req
         for (int i = 0; i < 70; i++) begin
            cap = sb.loaded_prefix() + 3;
            send_req(rnd_req((cap > NSLOT - 1) ? NSLOT - 1 : cap));
         end
         drain();
      end
      repeat (1200) @(posedge clock);   // one full trace worth of slack

      if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
